[hw/rtl/mandelbrot_escape_time_unit_defines.svh]
// Assertion macros used by the checker of the escape time unit.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MET_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MET_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/met_pkg.sv]
// Types, constants and register codes of the Mandelbrot escape time unit.
package met_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = COORD_BITS - 4;
    localparam int MAX_SIDE   = 4096;
    localparam int SIDE_BITS  = $clog2(MAX_SIDE);
    localparam int INDEX_BITS = 12;
    localparam int STEP_BITS  = 31;
    localparam int START_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int PROD_BITS  = INDEX_BITS + STEP_BITS;
    localparam int ADDR_BITS  = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [COORD_BITS-1:0] TWO  = COORD_BITS'(64'sd2 <<< FRAC_BITS);
    localparam logic [COORD_BITS:0]          FOUR = (COORD_BITS+1)'(64'd4 << FRAC_BITS);

    localparam logic [START_BITS-1:0] RST_REAL_START = 32'hE000_0000;
    localparam logic [START_BITS-1:0] RST_IMAG_START = 32'hE800_0000;
    localparam logic [STEP_BITS-1:0]  RST_REAL_STEP  = 31'd196608;
    localparam logic [STEP_BITS-1:0]  RST_IMAG_STEP  = 31'd196608;
    localparam logic [COUNT_BITS-1:0] RST_ITER_LIMIT = 16'd100;

    localparam logic [2:0] REG_REAL_START = 3'd0;
    localparam logic [2:0] REG_IMAG_START = 3'd1;
    localparam logic [2:0] REG_REAL_STEP  = 3'd2;
    localparam logic [2:0] REG_IMAG_STEP  = 3'd3;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd4;

    typedef struct packed {
        logic [START_BITS-1:0] real_start;
        logic [START_BITS-1:0] imag_start;
        logic [STEP_BITS-1:0]  real_step;
        logic [STEP_BITS-1:0]  imag_step;
        logic [COUNT_BITS-1:0] iteration_limit;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] cr;
        logic [COORD_BITS-1:0] ci;
    } t_coord;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_core_state;

endpackage

[hw/rtl/met_front.sv]
// Front end: accepts pixel indices and maps them to the complex point c.
module met_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  met_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [met_pkg::INDEX_BITS-1:0] i_column,
    input  logic [met_pkg::INDEX_BITS-1:0] i_row,
    output logic                         o_push,
    input  logic                         i_queue_ready,
    output met_pkg::t_coord              o_coord
);

    logic                             r_valid;
    logic [met_pkg::COORD_BITS-1:0]   r_prod_r;
    logic [met_pkg::COORD_BITS-1:0]   r_prod_i;
    logic [met_pkg::PROD_BITS-1:0]    w_prod_r;
    logic [met_pkg::PROD_BITS-1:0]    w_prod_i;
    logic [met_pkg::INDEX_BITS-1:0]   w_col;
    logic [met_pkg::INDEX_BITS-1:0]   w_row;
    logic                             w_take;

    // Indices wrap at the largest image side.
    assign w_col = met_pkg::INDEX_BITS'(i_column[met_pkg::SIDE_BITS-1:0]);
    assign w_row = met_pkg::INDEX_BITS'(i_row[met_pkg::SIDE_BITS-1:0]);

    assign w_prod_r = met_pkg::PROD_BITS'(w_col) * met_pkg::PROD_BITS'(i_cfg.real_step);
    assign w_prod_i = met_pkg::PROD_BITS'(w_row) * met_pkg::PROD_BITS'(i_cfg.imag_step);

    assign o_push  = r_valid && i_queue_ready;
    assign o_ready = !r_valid || o_push;
    assign w_take  = i_valid && o_ready;

    assign o_coord.cr = i_cfg.real_start + r_prod_r;
    assign o_coord.ci = i_cfg.imag_start + r_prod_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_prod_r <= w_prod_r[met_pkg::COORD_BITS-1:0];
            r_prod_i <= w_prod_i[met_pkg::COORD_BITS-1:0];
        end
    end

endmodule

[hw/rtl/met_queue.sv]
// Short queue of complex points between the front end and the iteration core.
module met_queue #(
    parameter int DEPTH = met_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  met_pkg::t_coord i_coord,
    output logic            o_valid,
    input  logic            i_pop,
    output met_pkg::t_coord o_coord
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    met_pkg::t_coord     r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                w_wr;
    logic                w_rd;

    assign o_ready = r_count != CNT_BITS'(DEPTH);
    assign o_valid = r_count != '0;
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;
    assign o_coord = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_coord;
        end
    end

endmodule

[hw/rtl/met_core.sv]
// Iteration core: runs z = z^2 + c on one point and holds the count for output.
module met_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [met_pkg::COUNT_BITS-1:0] i_limit,
    input  logic                           i_valid,
    output logic                           o_pop,
    input  met_pkg::t_coord                i_coord,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [met_pkg::COUNT_BITS-1:0] o_count
);

    localparam int CB = met_pkg::COORD_BITS;
    localparam int FB = met_pkg::FRAC_BITS;

    met_pkg::t_core_state r_state, n_state;

    logic signed [CB-1:0]          r_cr, n_cr;
    logic signed [CB-1:0]          r_ci, n_ci;
    logic signed [CB-1:0]          r_zr, n_zr;
    logic signed [CB-1:0]          r_zi, n_zi;
    logic [CB-1:0]                 r_r2, n_r2;
    logic [CB-1:0]                 r_i2, n_i2;
    logic [CB-1:0]                 r_cross, n_cross;
    logic [met_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic                          r_out_valid, n_out_valid;
    logic [met_pkg::COUNT_BITS-1:0] r_out_count, n_out_count;

    logic signed [2*CB-1:0] w_rr;
    logic signed [2*CB-1:0] w_ii;
    logic signed [2*CB-1:0] w_ri;
    logic [CB:0]            w_sum;
    logic                   w_large;

    assign w_rr    = r_zr * r_zr;
    assign w_ii    = r_zi * r_zi;
    assign w_ri    = r_zr * r_zi;
    assign w_sum   = {1'b0, r_r2} + {1'b0, r_i2};
    assign w_large = (r_zr >= met_pkg::TWO) || (r_zr <= -met_pkg::TWO) ||
                     (r_zi >= met_pkg::TWO) || (r_zi <= -met_pkg::TWO);

    assign o_valid = r_out_valid;
    assign o_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= met_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr        <= n_cr;
        r_ci        <= n_ci;
        r_zr        <= n_zr;
        r_zi        <= n_zi;
        r_r2        <= n_r2;
        r_i2        <= n_i2;
        r_cross     <= n_cross;
        r_count     <= n_count;
        r_out_count <= n_out_count;
    end

    always_comb begin
        n_state     = r_state;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_r2        = r_r2;
        n_i2        = r_i2;
        n_cross     = r_cross;
        n_count     = r_count;
        n_out_count = r_out_count;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        unique case (r_state)
            met_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_cr    = i_coord.cr;
                    n_ci    = i_coord.ci;
                    n_zr    = i_coord.cr;
                    n_zi    = i_coord.ci;
                    n_count = '0;
                    n_state = met_pkg::ST_MUL;
                end
            end
            met_pkg::ST_MUL: begin
                if ((r_count >= i_limit) || w_large) begin
                    n_state = met_pkg::ST_DONE;
                end else begin
                    n_r2    = w_rr[FB+CB-1:FB];
                    n_i2    = w_ii[FB+CB-1:FB];
                    n_cross = w_ri[FB+CB-2:FB-1];
                    n_state = met_pkg::ST_ACC;
                end
            end
            met_pkg::ST_ACC: begin
                if (w_sum >= met_pkg::FOUR) begin
                    n_state = met_pkg::ST_DONE;
                end else begin
                    n_count = r_count + 1'b1;
                    n_zr    = $signed(r_r2 - r_i2) + r_cr;
                    n_zi    = $signed(r_cross) + r_ci;
                    n_state = met_pkg::ST_MUL;
                end
            end
            met_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_count;
                    n_state     = met_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = met_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/mandelbrot_escape_time_unit.sv]
// Top level of the Mandelbrot escape time unit with its register file.
//
// Each transfer on the input stream carries one pixel's column and row; each
// transfer on the output stream carries that pixel's iteration count, in the
// same order. In the iteration core, every counted round of a pixel passes
// through a multiply state for the three 32x32 products of z and an accumulate
// state for the magnitude test and the update of z. Around the rounds, the core
// takes the point, makes the final test and hands the count to the output
// register. The front end registers the products for c and works ahead of the
// core through a short point queue, so its latency is hidden while the core is
// busy. Write the registers only while no pixel is in flight.
module mandelbrot_escape_time_unit #(
    parameter int QUEUE_DEPTH = met_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // Fields from bit 0 up: column [11:0], row [23:12].
    input  logic [23:0]                   i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // Fields from bit 0 up: iteration_count [15:0].
    output logic [15:0]                   o_m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [met_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    met_pkg::t_cfg   r_cfg;
    met_pkg::t_coord w_front_coord;
    met_pkg::t_coord w_queue_coord;
    logic            w_push;
    logic            w_queue_ready;
    logic            w_queue_valid;
    logic            w_pop;
    logic [2:0]      w_index;
    logic            w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[4:2];
    assign w_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_start      <= met_pkg::RST_REAL_START;
            r_cfg.imag_start      <= met_pkg::RST_IMAG_START;
            r_cfg.real_step       <= met_pkg::RST_REAL_STEP;
            r_cfg.imag_step       <= met_pkg::RST_IMAG_STEP;
            r_cfg.iteration_limit <= met_pkg::RST_ITER_LIMIT;
        end else if (w_write) begin
            unique case (w_index)
                met_pkg::REG_REAL_START: r_cfg.real_start      <= pwdata;
                met_pkg::REG_IMAG_START: r_cfg.imag_start      <= pwdata;
                met_pkg::REG_REAL_STEP:  r_cfg.real_step       <= pwdata[30:0];
                met_pkg::REG_IMAG_STEP:  r_cfg.imag_step       <= pwdata[30:0];
                met_pkg::REG_ITER_LIMIT: r_cfg.iteration_limit <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            met_pkg::REG_REAL_START: prdata = r_cfg.real_start;
            met_pkg::REG_IMAG_START: prdata = r_cfg.imag_start;
            met_pkg::REG_REAL_STEP:  prdata = {1'b0, r_cfg.real_step};
            met_pkg::REG_IMAG_STEP:  prdata = {1'b0, r_cfg.imag_step};
            met_pkg::REG_ITER_LIMIT: prdata = {16'd0, r_cfg.iteration_limit};
            default:                 prdata = '0;
        endcase
    end

    met_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_column     (i_s_tdata[11:0]),
        .i_row        (i_s_tdata[23:12]),
        .o_push       (w_push),
        .i_queue_ready(w_queue_ready),
        .o_coord      (w_front_coord)
    );

    met_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_ready(w_queue_ready),
        .i_coord(w_front_coord),
        .o_valid(w_queue_valid),
        .i_pop  (w_pop),
        .o_coord(w_queue_coord)
    );

    met_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_limit(r_cfg.iteration_limit),
        .i_valid(w_queue_valid),
        .o_pop  (w_pop),
        .i_coord(w_queue_coord),
        .o_valid(o_m_tvalid),
        .i_ready(i_m_tready),
        .o_count(o_m_tdata)
    );

endmodule

[hw/rtl/met_checker.sv]
// Port-level checker of the Mandelbrot escape time unit and its bind.
`include "mandelbrot_escape_time_unit_defines.svh"

module met_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [15:0]                   o_m_tdata,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [met_pkg::ADDR_BITS-1:0] paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata,
    input logic                          pready
);

    logic [met_pkg::COUNT_BITS-1:0] r_limit;
    logic [3:0]                     r_pending;
    logic                           w_in_transfer;
    logic                           w_out_transfer;
    logic                           w_limit_read;
    logic                           w_out_stall;

    assign w_in_transfer  = i_s_tvalid && o_s_tready;
    assign w_out_transfer = o_m_tvalid && i_m_tready;
    assign w_limit_read   = psel && !pwrite && paddr[4:2] == met_pkg::REG_ITER_LIMIT;
    assign w_out_stall    = o_m_tvalid && !i_m_tready;

    // Shadow copy of the iteration limit, tracked from register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= met_pkg::RST_ITER_LIMIT;
        end else if (psel && penable && pwrite && pready &&
                     paddr[4:2] == met_pkg::REG_ITER_LIMIT) begin
            r_limit <= pwdata[15:0];
        end
    end

    // Number of pixels accepted whose counts have not yet been transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_transfer && !w_out_transfer) begin
            r_pending <= r_pending + 1'b1;
        end else if (w_out_transfer && !w_in_transfer) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    `MET_ASSERT_ALWAYS(a_no_output_after_reset, i_clk,
        !i_rst_n |=> !o_m_tvalid, "output valid right after reset")
    `MET_ASSERT_CLK(a_count_within_limit, i_clk, i_rst_n,
        o_m_tvalid |-> o_m_tdata <= r_limit, "count above limit")
    `MET_ASSERT_CLK(a_limit_readback, i_clk, i_rst_n,
        w_limit_read |-> prdata == {16'd0, r_limit}, "limit readback mismatch")
    `MET_ASSERT_CLK(a_output_held, i_clk, i_rst_n,
        w_out_stall |=> (o_m_tvalid && $stable(o_m_tdata)), "stalled output changed")
    `MET_ASSERT_CLK(a_result_has_pixel, i_clk, i_rst_n,
        o_m_tvalid |-> r_pending != '0, "result without an accepted pixel")

endmodule

bind mandelbrot_escape_time_unit met_checker u_met_checker (.*);
